// File: src/mvm_pkg.sv
package mvm_pkg;

   // Size of the vector store; the column counters index it.
   localparam int MAX_COLUMNS = 1024;
   localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

   // Field widths fixed by the interface.
   localparam int LEN_W  = 11;
   localparam int ROWS_W = 16;
   localparam int ELEM_W = 8;
   localparam int PROD_W = 2 * ELEM_W;
   localparam int SUM_W  = 26;

   // Width that holds both a column count and the row_length register.
   localparam int CNT_W = (COL_W + 1 > LEN_W) ? COL_W + 1 : LEN_W;

   // Queue between the front and back parts.
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = (LEN_W > ROWS_W) ? LEN_W : ROWS_W;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_COUNT  = 1'b1;

   localparam logic [LEN_W-1:0]  ROW_LENGTH_RESET = 11'd1024;
   localparam logic [ROWS_W-1:0] ROW_COUNT_RESET  = 16'd1;

   // Input action codes.
   localparam logic ACTION_LOAD   = 1'b0;
   localparam logic ACTION_MATRIX = 1'b1;

   typedef struct packed {
      logic [CNT_W-1:0]  length;
      logic [ROWS_W-1:0] rows;
   } cfg_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] element;
      logic signed [ELEM_W-1:0] vec;
      logic                     end_row;
      logic [ROWS_W-1:0]        row_index;
      logic                     last_row;
   } q_entry_type;

   // Row length as the datapath uses it: zero acts as one, and values past
   // the store size are clamped to it.
   function automatic logic [CNT_W-1:0] eff_length(input logic [LEN_W-1:0] value);
      logic [CNT_W-1:0] wide;
      wide = CNT_W'(value);
      if (value == '0) begin
         return CNT_W'(1);
      end else if (wide > CNT_W'(MAX_COLUMNS)) begin
         return CNT_W'(MAX_COLUMNS);
      end
      return wide;
   endfunction

   function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROWS_W-1:0] value);
      return (value == '0) ? ROWS_W'(1) : value;
   endfunction

endpackage

// File: src/mvm_if.sv
interface mvm_req_if import mvm_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic                     action;
   logic signed [ELEM_W-1:0] element;

   modport source (output valid, output action, output element, input ready);
   modport sink (input valid, input action, input element, output ready);
endinterface

interface mvm_rsp_if import mvm_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [SUM_W-1:0] row_sum;
   logic [ROWS_W-1:0]       row_index;
   logic                    last_row;

   modport source (output valid, output row_sum, output row_index, output last_row,
                   input ready);
   modport sink (input valid, input row_sum, input row_index, input last_row,
                 output ready);
endinterface

// File: src/int8_matrix_vector_multiply.sv
// Signed int8 matrix-vector product with a 26-bit wrapping accumulator.
// The req_bus channel carries one element per transfer: action low loads
// the next vector element into the 1024-entry store, action high supplies
// the next matrix element in row-major order. After the last element of a
// row, one transfer on rsp_bus returns the row sum, the row index and a
// flag set on the final row of the product.
// Registers row_length and row_count are written through the csr_ port
// and should only change while the block is idle.
// Throughput is one element per cycle unless rsp_bus stalls; the single
// multiply-accumulate in the back part and the one-port vector store each
// handle one element a cycle. A row result passes the read stage, the
// queue, the product register and the result register before rsp_bus.
// Reset clears all pointers, counters and the running sum; the vector
// store is not cleared and must be loaded before use. No clearing pass.
// When the receiver stalls, the result register holds, the back part
// stops and the four-entry queue fills; req_bus keeps taking elements
// until that queue can no longer take the one in flight.
module int8_matrix_vector_multiply import mvm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mvm_req_if.sink               req_bus,
   mvm_rsp_if.source             rsp_bus,
   input  logic                  csr_write_enable,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data
);

   logic [LEN_W-1:0]  row_length_ff, row_length_in;
   logic [ROWS_W-1:0] row_count_ff, row_count_in;

   cfg_type           cfg;
   logic              push;
   q_entry_type       push_data;
   logic              pop;
   logic              q_valid;
   q_entry_type       q_head;
   logic [QCNT_W-1:0] q_count;

   // Register writes; an index outside the list leaves both untouched.
   always_comb begin
      row_length_in = row_length_ff;
      row_count_in  = row_count_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ROW_LENGTH: begin
               row_length_in = csr_write_data[LEN_W-1:0];
            end
            CSR_ROW_COUNT: begin
               row_count_in = csr_write_data[ROWS_W-1:0];
            end
            default: begin
               row_length_in = row_length_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_length_ff <= ROW_LENGTH_RESET;
         row_count_ff  <= ROW_COUNT_RESET;
      end else begin
         row_length_ff <= row_length_in;
         row_count_ff  <= row_count_in;
      end
   end

   // The datapath sees the lengths already cleaned up: zero acts as one and
   // an oversized row length is clamped to the store size.
   assign cfg.length = eff_length(row_length_ff);
   assign cfg.rows   = eff_rows(row_count_ff);

   // The front part keeps the load, column and row pointers and reads the
   // vector store; it hands each matrix element with its operand to the queue.
   mvm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg),
      .q_count   (q_count),
      .push      (push),
      .push_data (push_data)
   );

   mvm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .not_empty (q_valid),
      .head      (q_head),
      .count     (q_count)
   );

   // The back part multiplies, accumulates and holds the result register.
   mvm_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_valid (q_valid),
      .q_head  (q_head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// File: src/mvm_front.sv
module mvm_front import mvm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   mvm_req_if.sink           req_bus,
   input  cfg_type           cfg,
   input  logic [QCNT_W-1:0] q_count,
   output logic              push,
   output q_entry_type       push_data
);

   logic [ELEM_W-1:0] vec_mem [MAX_COLUMNS];

   logic [COL_W-1:0]  load_ptr_ff, load_ptr_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROWS_W-1:0] row_ff, row_in;
   logic              s1_valid_ff, s1_valid_in;

   logic signed [ELEM_W-1:0] s1_element_ff;
   logic                     s1_end_ff;
   logic [ROWS_W-1:0]        s1_index_ff;
   logic                     s1_last_ff;
   logic signed [ELEM_W-1:0] vec_rd_ff;

   logic              accept;
   logic              is_matrix;
   logic [CNT_W-1:0]  load_next;
   logic [CNT_W-1:0]  col_next;
   logic              end_row;
   logic              last_row;

   // Room is needed for the new item and the one already in the read stage.
   assign req_bus.ready = (QCNT_W'(q_count) + QCNT_W'(s1_valid_ff)) < QCNT_W'(QDEPTH);
   assign accept    = req_bus.valid && req_bus.ready;
   assign is_matrix = (req_bus.action == ACTION_MATRIX);

   always_comb begin
      load_next = CNT_W'(load_ptr_ff) + CNT_W'(1);
      col_next  = CNT_W'(col_ff) + CNT_W'(1);
      end_row   = (col_next >= cfg.length);
      last_row  = ({1'b0, row_ff} + 17'd1) >= {1'b0, cfg.rows};

      load_ptr_in = load_ptr_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      s1_valid_in = accept && is_matrix;
      if (accept && !is_matrix) begin
         load_ptr_in = (load_next >= cfg.length) ? '0 : load_next[COL_W-1:0];
      end
      if (accept && is_matrix) begin
         col_in = end_row ? '0 : col_next[COL_W-1:0];
         if (end_row) begin
            row_in = last_row ? '0 : row_ff + ROWS_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ptr_ff <= '0;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         load_ptr_ff <= load_ptr_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_matrix) begin
         vec_mem[load_ptr_ff] <= req_bus.element;
      end
      if (accept && is_matrix) begin
         vec_rd_ff     <= vec_mem[col_ff];
         s1_element_ff <= req_bus.element;
         s1_end_ff     <= end_row;
         s1_index_ff   <= row_ff;
         s1_last_ff    <= last_row;
      end
   end

   assign push                = s1_valid_ff;
   assign push_data.element   = s1_element_ff;
   assign push_data.vec       = vec_rd_ff;
   assign push_data.end_row   = s1_end_ff;
   assign push_data.row_index = s1_index_ff;
   assign push_data.last_row  = s1_last_ff;

endmodule

// File: src/mvm_queue.sv
module mvm_queue import mvm_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  q_entry_type       push_data,
   input  logic              pop,
   output logic              not_empty,
   output q_entry_type       head,
   output logic [QCNT_W-1:0] count
);

   q_entry_type       entries [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      count_in = count_ff + QCNT_W'(push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries[wr_ptr_ff] <= push_data;
      end
   end

   assign not_empty = (count_ff != '0);
   assign head      = entries[rd_ptr_ff];
   assign count     = count_ff;

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == QCNT_W'(QDEPTH)))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == '0))
      else $error("queue read while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count lost a write");
`endif

endmodule

// File: src/mvm_back.sv
module mvm_back import mvm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  q_entry_type q_head,
   output logic        pop,
   mvm_rsp_if.source   rsp_bus
);

   logic                     a_valid_ff;
   logic signed [PROD_W-1:0] a_prod_ff;
   logic                     a_end_ff;
   logic [ROWS_W-1:0]        a_index_ff;
   logic                     a_last_ff;

   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [SUM_W-1:0]  out_sum_ff;
   logic [ROWS_W-1:0]        out_index_ff;
   logic                     out_last_ff;

   logic                     advance;
   logic signed [SUM_W-1:0]  acc;

   // The whole back part moves together whenever the output register frees up.
   assign advance = !out_valid_ff || rsp_bus.ready;
   assign pop     = advance && q_valid;
   assign acc     = sum_ff + SUM_W'(a_prod_ff);

   always_comb begin
      sum_in       = sum_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = a_valid_ff && a_end_ff;
         if (a_valid_ff) begin
            sum_in = a_end_ff ? '0 : acc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         sum_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            a_valid_ff <= q_valid;
         end
         sum_ff       <= sum_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         a_prod_ff  <= PROD_W'(q_head.element) * PROD_W'(q_head.vec);
         a_end_ff   <= q_head.end_row;
         a_index_ff <= q_head.row_index;
         a_last_ff  <= q_head.last_row;
      end
      if (advance && a_valid_ff && a_end_ff) begin
         out_sum_ff   <= acc;
         out_index_ff <= a_index_ff;
         out_last_ff  <= a_last_ff;
      end
   end

   assign rsp_bus.valid     = out_valid_ff;
   assign rsp_bus.row_sum   = out_sum_ff;
   assign rsp_bus.row_index = out_index_ff;
   assign rsp_bus.last_row  = out_last_ff;

endmodule

// File: test/testbench.sv
module testbench import mvm_pkg::*; ();

   // Clock, idling and run length figures.
   localparam int HALF_PERIOD    = 6;
   localparam int IDLE_PERCENT   = 34;
   localparam int RANDOM_ITEMS   = 850;
   localparam int SETTLE_CYCLES  = 8;
   localparam int STALL_CYCLES   = 400;
   localparam int TIMEOUT_CYCLES = 400_000;

   // One element as it travels on the request channel.
   typedef struct packed {
      logic                     action;
      logic signed [ELEM_W-1:0] element;
   } stream_item_type;

   // One row result as it should appear on the response channel.
   typedef struct packed {
      logic signed [SUM_W-1:0] row_sum;
      logic [ROWS_W-1:0]       row_index;
      logic                    last_row;
   } row_result_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   mvm_req_if req_bus ();
   mvm_rsp_if rsp_bus ();

   int8_matrix_vector_multiply dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus),
      .rsp_bus          (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Elements waiting to be offered, and row results still owed by the block.
   stream_item_type elements_to_send[$];
   row_result_type  row_sums_due[$];
   int unsigned     mismatches = 0;

   // When steady is set, neither side idles. hold_kick starts a long stall of
   // the response channel that the counter below times on its own.
   logic        steady;
   logic        hold_kick;
   int unsigned hold_left;

   // Our own copy of the block's state and registers. Reset values are the
   // declaration values, since reset is applied only once at the start.
   logic signed [ELEM_W-1:0] vector_image [MAX_COLUMNS];
   int unsigned              fill_ptr   = 0;
   int unsigned              column_ptr = 0;
   logic [ROWS_W-1:0]        row_ptr    = '0;
   logic [SUM_W-1:0]         row_acc    = '0;
   logic [LEN_W-1:0]         length_reg = ROW_LENGTH_RESET;
   logic [ROWS_W-1:0]        rows_reg   = ROW_COUNT_RESET;

   // A row length of zero behaves as one, and anything past the store size
   // is clamped to the store size.
   function automatic int unsigned active_columns();
      if (length_reg == '0) begin
         return 1;
      end else if (length_reg > MAX_COLUMNS) begin
         return MAX_COLUMNS;
      end
      return length_reg;
   endfunction

   // A row count of zero behaves as one.
   function automatic int unsigned active_rows();
      return (rows_reg == '0) ? 1 : rows_reg;
   endfunction

   // Applies one accepted element to the state copy. A matrix element that
   // closes a row queues the row result that the block must return.
   function automatic void accumulate_element(input logic action,
                                              input logic signed [ELEM_W-1:0] element);
      int unsigned              columns;
      logic signed [PROD_W-1:0] product;
      row_result_type           result;
      columns = active_columns();
      if (action == ACTION_LOAD) begin
         // Loads write the vector copy and move the fill pointer; they never touch the row state.
         if (fill_ptr < MAX_COLUMNS) begin
            vector_image[fill_ptr] = element;
         end
         fill_ptr++;
         if (fill_ptr >= columns) begin
            fill_ptr = 0;
         end
      end else begin
         product = element * vector_image[column_ptr];
         // The accumulator wraps at its own width in two's complement.
         row_acc = row_acc + {{(SUM_W - PROD_W){product[PROD_W-1]}}, product};
         column_ptr++;
         if (column_ptr >= columns) begin
            // A pointer left past a shortened row still finishes its element
            // here and then returns to zero. Likewise a row counter at or past
            // a lowered row count marks its row as the last one.
            column_ptr       = 0;
            result.row_sum   = row_acc;
            result.row_index = row_ptr;
            result.last_row  = (int'(row_ptr) + 1 >= active_rows());
            row_sums_due.push_back(result);
            row_acc = '0;
            row_ptr = result.last_row ? '0 : row_ptr + 1'b1;
         end
      end
   endfunction

   // Request side: on every accepted transfer the state copy is advanced,
   // and a new element is put up whenever the channel is free, unless this
   // cycle is one of the random idle ones.
   always @(posedge clock) begin
      stream_item_type next_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            accumulate_element(req_bus.action, req_bus.element);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (elements_to_send.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
               next_item = elements_to_send.pop_front();
               req_bus.valid   <= 1'b1;
               req_bus.action  <= next_item.action;
               req_bus.element <= next_item.element;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Long response stall, counted here so that the sender keeps offering
   // elements while the block backs up and finally refuses its input.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_kick) begin
         hold_left <= STALL_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response side readiness: random idling, none in steady stretches, and
   // always low during a long stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= (hold_left == 0) &&
                          (steady || $urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Every accepted result is checked against the oldest row still owed.
   always @(posedge clock) begin
      row_result_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (row_sums_due.size() == 0) begin
            $error("row_sum: no row pending, got %0d", rsp_bus.row_sum);
            mismatches++;
         end else begin
            due = row_sums_due.pop_front();
            if (rsp_bus.row_sum !== due.row_sum) begin
               $error("row_sum: expected %0d, got %0d", due.row_sum, rsp_bus.row_sum);
               mismatches++;
            end
            if (rsp_bus.row_index !== due.row_index) begin
               $error("row_index: expected %0d, got %0d", due.row_index, rsp_bus.row_index);
               mismatches++;
            end
            if (rsp_bus.last_row !== due.last_row) begin
               $error("last_row: expected %0d, got %0d", due.last_row, rsp_bus.last_row);
               mismatches++;
            end
         end
      end
   end

   function automatic void send(input logic action, input logic signed [ELEM_W-1:0] element);
      stream_item_type item;
      item.action  = action;
      item.element = element;
      elements_to_send.push_back(item);
   endfunction

   // Mostly uniform bytes, with the extremes and the values around zero
   // drawn more often than chance would give them.
   function automatic logic signed [ELEM_W-1:0] random_element();
      int unsigned pick;
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         return {1'b1, {(ELEM_W-1){1'b0}}};
      end else if (pick == 1) begin
         return {1'b0, {(ELEM_W-1){1'b1}}};
      end else if (pick == 2) begin
         return '0;
      end else if (pick == 3) begin
         return '1;
      end
      return ELEM_W'($urandom);
   endfunction

   // Register write on the configuration port; the copy follows once the
   // write edge has passed.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] reg_index, input int unsigned value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= reg_index;
      csr_write_data   <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (reg_index == CSR_ROW_LENGTH) begin
         length_reg = LEN_W'(value);
      end else begin
         rows_reg = ROWS_W'(value);
      end
   endtask

   // Waits until every element has been taken and every owed row has come
   // back, then lets the pipeline drain for a while more, since loads and
   // unfinished rows leave work in flight without any result to show for it.
   // Sampling on the falling edge keeps the check clear of the rising-edge
   // updates.
   task automatic settle();
      do begin
         @(negedge clock);
      end while (elements_to_send.size() != 0 || req_bus.valid || row_sums_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int unsigned random_sent;
      int unsigned phase;
      int unsigned columns;
      int unsigned row_span;
      int unsigned pick;
      int unsigned value;

      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = CSR_ROW_LENGTH;
      csr_write_data   = '0;
      req_bus.valid    = 1'b0;
      req_bus.action   = ACTION_LOAD;
      req_bus.element  = '0;
      rsp_bus.ready    = 1'b0;
      steady           = 1'b0;
      hold_kick        = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A three-column vector holding both extremes and zero,
      // two full rows that finish a two-row product, a third row with a loaded
      // element in the middle of it, and a row left unfinished.
      write_reg(CSR_ROW_LENGTH, 3);
      write_reg(CSR_ROW_COUNT, 2);
      send(ACTION_LOAD, 127);
      send(ACTION_LOAD, -128);
      send(ACTION_LOAD, 0);
      send(ACTION_MATRIX, -128);
      send(ACTION_MATRIX, -128);
      send(ACTION_MATRIX, 127);
      send(ACTION_MATRIX, 127);
      send(ACTION_MATRIX, 127);
      send(ACTION_MATRIX, -1);
      send(ACTION_MATRIX, 1);
      send(ACTION_LOAD, 5);
      send(ACTION_MATRIX, 2);
      send(ACTION_MATRIX, 3);
      send(ACTION_MATRIX, 1);
      settle();

      // Zero row length and zero row count both act as one. The column and
      // row pointers are now past the new limits, so the next matrix element
      // closes its row at once and that row is marked last.
      write_reg(CSR_ROW_LENGTH, 0);
      write_reg(CSR_ROW_COUNT, 0);
      send(ACTION_MATRIX, -2);
      send(ACTION_LOAD, -128);
      send(ACTION_MATRIX, -128);
      send(ACTION_MATRIX, 127);
      settle();

      // Row length above the store size is clamped to the full store. One
      // row of products of two most negative elements gives the largest sum
      // the block can form, and afterwards every vector entry holds a written value.
      write_reg(CSR_ROW_LENGTH, (1 << LEN_W) - 1);
      write_reg(CSR_ROW_COUNT, 1);
      repeat (MAX_COLUMNS) send(ACTION_LOAD, -128);
      repeat (MAX_COLUMNS) send(ACTION_MATRIX, -128);
      settle();

      // Back pressure: one-column rows produce a result for every element
      // while the response side is held off, so the internal queue fills and
      // the request side has to stall.
      write_reg(CSR_ROW_LENGTH, 1);
      write_reg(CSR_ROW_COUNT, 8);
      steady <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b1;
      @(posedge clock);
      hold_kick <= 1'b0;
      send(ACTION_LOAD, random_element());
      repeat (40) send(ACTION_MATRIX, random_element());
      settle();
      steady <= 1'b0;

      // Random phases. Each may change either register while idle, then
      // streams whole products with random contents most of the time; the
      // rest are random noise or products cut short, which leave pointers
      // mid-row for the next register change.
      random_sent = 0;
      phase       = 0;
      while (random_sent < RANDOM_ITEMS) begin
         steady <= (phase >= 12 && phase < 16);
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               value = 0;
            end else if (pick < 13) begin
               value = $urandom_range(1, 4);
            end else if (pick < 18) begin
               value = $urandom_range(5, 16);
            end else begin
               value = $urandom_range(17, 48);
            end
            write_reg(CSR_ROW_LENGTH, value);
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
               value = 0;
            end else if (pick == 1) begin
               value = (1 << ROWS_W) - 1;
            end else if (pick == 2) begin
               value = $urandom_range(0, (1 << ROWS_W) - 1);
            end else if (pick < 14) begin
               value = $urandom_range(1, 3);
            end else begin
               value = $urandom_range(4, 8);
            end
            write_reg(CSR_ROW_COUNT, value);
         end
         columns = active_columns();
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 15)) begin
               send($urandom_range(0, 1) ? ACTION_MATRIX : ACTION_LOAD, random_element());
            end
         end else begin
            repeat ($urandom_range(1, 2)) begin
               // Now and then the previous vector is reused as it stands.
               if ($urandom_range(0, 3) != 0) begin
                  repeat (columns) send(ACTION_LOAD, random_element());
               end
               // Huge row counts are only ever streamed in part.
               row_span = $urandom_range(1, 6);
               if (row_span > active_rows()) begin
                  row_span = active_rows();
               end
               value = columns * row_span;
               if ($urandom_range(0, 5) == 0) begin
                  value = $urandom_range(1, value);
               end
               repeat (value) send(ACTION_MATRIX, random_element());
            end
         end
         random_sent += elements_to_send.size();
         settle();
         phase++;
      end

      if (mismatches == 0) begin
         $display("int8_matrix_vector_multiply: match");
      end else begin
         $display("int8_matrix_vector_multiply: mismatch");
      end
      $finish;
   end

   // Ends a run that hangs, far past the slowest correct one.
   initial begin
      #(2 * HALF_PERIOD * TIMEOUT_CYCLES);
      $display("int8_matrix_vector_multiply: mismatch");
      $finish;
   end

endmodule
